FILE: rtl/core/sha1md_pkg.sv
package sha1md_pkg;

  localparam int QueueDepth = 4;

  localparam logic [31:0] K_ROUND_0 = 32'h5A827999;
  localparam logic [31:0] K_ROUND_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_ROUND_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_ROUND_3 = 32'hCA62C1D6;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [7:0] PAD_MARK_BYTE  = 8'h80;
  localparam logic [7:0] PAD_ZERO_BYTE  = 8'h00;
  localparam logic [5:0] LEN_START_FILL = 6'd56;
  localparam logic [5:0] LAST_FILL      = 6'd63;
  localparam logic [6:0] LAST_ROUND     = 7'd79;
  localparam logic [2:0] LAST_WORD      = 3'd4;
  localparam logic [2:0] LAST_LEN_BYTE  = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } back_state_t;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN,
    PH_DONE
  } pad_phase_t;

endpackage

FILE: rtl/core/sha1md_front.sv
module sha1md_front
  import sha1md_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] data_byte,
  input  logic       has_byte,
  input  logic       end_of_message,
  input  logic       data_valid,
  output logic       data_ready,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  logic       cmd_ready
);

  cmd_t hold;
  logic hold_valid;

  // A beat that carries neither a byte nor the end mark changes nothing and is dropped here.
  assign data_ready = !hold_valid || cmd_ready;
  assign cmd        = hold;
  assign cmd_valid  = hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (data_valid && data_ready) begin
      hold_valid <= has_byte || end_of_message;
    end else if (cmd_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && data_ready) begin
      hold.data <= data_byte;
      hold.has  <= has_byte;
      hold.last <= end_of_message;
    end
  end

endmodule

FILE: rtl/core/sha1md_queue.sv
module sha1md_queue
  import sha1md_pkg::*;
#(
  parameter int DEPTH = QueueDepth
)
(
  input  logic clk,
  input  logic rst,
  input  cmd_t push_cmd,
  input  logic push_valid,
  output logic push_ready,
  output cmd_t pop_cmd,
  output logic pop_valid,
  input  logic pop_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/sha1md_back.sv
module sha1md_back
  import sha1md_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        final_word,
  output logic        digest_valid,
  input  logic        digest_ready
);

  back_state_t state;
  back_state_t state_next;
  pad_phase_t  phase;
  logic        padding;
  logic        end_pend;
  logic [5:0]  fill;
  logic [63:0] message_bits;
  logic [2:0]  len_idx;
  logic [6:0]  round;
  logic [2:0]  emit_idx;
  logic [31:0] a, b, c, d, e;
  logic [31:0] hash_words [5];
  logic [31:0] block_words [16];

  logic        push_en;
  logic [7:0]  push_byte;
  logic        block_full;
  logic        pad_start;
  logic        emit_done;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] tmp;
  logic [31:0] sched_mix;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.has && fill == LAST_FILL) begin
            state_next = ST_ROUND;
          end else if (cmd.last) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (fill == LAST_FILL) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round == LAST_ROUND) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (padding && phase == PH_DONE) begin
          state_next = ST_EMIT;
        end else if (padding || end_pend) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (digest_ready && emit_idx == LAST_WORD) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready    = 1'b0;
    push_en      = 1'b0;
    push_byte    = cmd.data;
    digest_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        push_en   = cmd_valid && cmd.has;
      end
      ST_PAD: begin
        push_en = 1'b1;
        case (phase)
          PH_MARK: push_byte = PAD_MARK_BYTE;
          PH_LEN:  push_byte = message_bits[(LAST_LEN_BYTE - len_idx) * 8 +: 8];
          default: push_byte = PAD_ZERO_BYTE;
        endcase
      end
      ST_EMIT: begin
        digest_valid = 1'b1;
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  assign block_full = push_en && fill == LAST_FILL;
  assign pad_start  = (state == ST_IDLE && state_next == ST_PAD) ||
                      (state == ST_UPDATE && !padding && end_pend);
  assign emit_done  = digest_valid && digest_ready && emit_idx == LAST_WORD;

  assign digest_word = hash_words[emit_idx];
  assign word_index  = emit_idx;
  assign final_word  = emit_idx == LAST_WORD;

  always_comb begin
    if (round < 7'd20) begin
      f_val = (b & c) | (~b & d);
      k_val = K_ROUND_0;
    end else if (round < 7'd40) begin
      f_val = b ^ c ^ d;
      k_val = K_ROUND_1;
    end else if (round < 7'd60) begin
      f_val = (b & c) | (b & d) | (c & d);
      k_val = K_ROUND_2;
    end else begin
      f_val = b ^ c ^ d;
      k_val = K_ROUND_3;
    end
  end

  assign tmp       = {a[26:0], a[31:27]} + f_val + e + k_val + block_words[0];
  assign sched_mix = block_words[13] ^ block_words[8] ^ block_words[2] ^ block_words[0];

  // During the rounds the block buffer doubles as the sliding message schedule.
  always_ff @(posedge clk) begin
    if (state == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        block_words[i] <= block_words[i + 1];
      end
      block_words[15] <= {sched_mix[30:0], sched_mix[31]};
    end else if (push_en) begin
      if (fill[1:0] == 2'd0) begin
        block_words[fill[5:2]] <= {push_byte, 24'd0};
      end else begin
        block_words[fill[5:2]][(2'd3 - fill[1:0]) * 8 +: 8] <= push_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_next == ST_ROUND && state != ST_ROUND) begin
      a <= hash_words[0];
      b <= hash_words[1];
      c <= hash_words[2];
      d <= hash_words[3];
      e <= hash_words[4];
    end else if (state == ST_ROUND) begin
      a <= tmp;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= PH_MARK;
      padding      <= 1'b0;
      end_pend     <= 1'b0;
      fill         <= '0;
      message_bits <= '0;
      len_idx      <= '0;
      round        <= '0;
      emit_idx     <= '0;
      for (int i = 0; i < 5; i++) begin
        hash_words[i] <= H_INIT[i];
      end
    end else begin
      state <= state_next;
      if (push_en) begin
        fill <= fill + 1'b1;
      end
      if (state == ST_IDLE && push_en) begin
        message_bits <= message_bits + 64'd8;
      end
      if (state == ST_IDLE && block_full) begin
        end_pend <= cmd.last;
      end
      if (pad_start) begin
        padding  <= 1'b1;
        end_pend <= 1'b0;
        phase    <= PH_MARK;
        len_idx  <= '0;
      end else if (state == ST_PAD) begin
        case (phase)
          PH_MARK, PH_ZERO: begin
            phase <= (fill + 1'b1 == LEN_START_FILL) ? PH_LEN : PH_ZERO;
          end
          PH_LEN: begin
            len_idx <= len_idx + 1'b1;
            if (len_idx == LAST_LEN_BYTE) begin
              phase <= PH_DONE;
            end
          end
          default: phase <= PH_DONE;
        endcase
      end
      if (state_next == ST_ROUND && state != ST_ROUND) begin
        round <= '0;
      end else if (state == ST_ROUND) begin
        round <= round + 1'b1;
      end
      if (state == ST_UPDATE) begin
        hash_words[0] <= hash_words[0] + a;
        hash_words[1] <= hash_words[1] + b;
        hash_words[2] <= hash_words[2] + c;
        hash_words[3] <= hash_words[3] + d;
        hash_words[4] <= hash_words[4] + e;
      end
      if (emit_done) begin
        emit_idx <= '0;
      end else if (digest_valid && digest_ready) begin
        emit_idx <= emit_idx + 1'b1;
      end
      if (emit_done) begin
        padding      <= 1'b0;
        fill         <= '0;
        message_bits <= '0;
        for (int i = 0; i < 5; i++) begin
          hash_words[i] <= H_INIT[i];
        end
      end
    end
  end

endmodule

FILE: rtl/core/sha1_message_digest_core.sv
// Path: an accepted end beat passes through the front hold register and the queue to the
// engine; padding then fills the block buffer, and one or two final compressions run before
// the digest beats are offered, one per cycle while digest_ready is high.
// Throughput: one byte beat per cycle into the engine while idle, none while it runs the
// rounds and chaining update of each 64-byte block.
// Synchronous reset loads the initial hash values and clears counts and the queue.
module sha1_message_digest_core
  import sha1md_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepth
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  input  logic        data_valid,
  output logic        data_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        final_word,
  output logic        digest_valid,
  input  logic        digest_ready
);

  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  sha1md_front u_front (
    .clk            (clk),
    .rst            (rst),
    .data_byte      (data_byte),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .data_valid     (data_valid),
    .data_ready     (data_ready),
    .cmd            (front_cmd),
    .cmd_valid      (front_valid),
    .cmd_ready      (front_ready)
  );

  sha1md_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (front_cmd),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_cmd    (back_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  sha1md_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (back_cmd),
    .cmd_valid    (back_valid),
    .cmd_ready    (back_ready),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .final_word   (final_word),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready)
  );

endmodule
